FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// every macro samples on the rising edge of clk and is disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LOB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent on the following edge
`define LOB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lob_pkg.sv
// shared types and constants for the limit order book matcher
// no dependencies
`timescale 1ns / 1ps

package lob_pkg;

  localparam int LOB_BOOK_DEPTH = 32;
  localparam int WORD_W         = 32;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef enum logic [1:0] {
    KIND_TRADE,
    KIND_RESTED,
    KIND_FILLED,
    KIND_REJECTED
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_TRADE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] price;
    logic [WORD_W-1:0] amount;
    logic [WORD_W-1:0] id;
  } entry_t;

endpackage

FILE: rtl/lob_order_if.sv
// valid/ready channel carrying one incoming limit order item
// depends on lob_pkg
`timescale 1ns / 1ps

interface lob_order_if;
  import lob_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] order_id;
  logic              side;
  logic [WORD_W-1:0] limit_price;
  logic [WORD_W-1:0] quantity;

  modport source (output valid, order_id, side, limit_price, quantity, input ready);
  modport sink   (input valid, order_id, side, limit_price, quantity, output ready);
endinterface

FILE: rtl/lob_result_if.sv
// valid/ready channel carrying one trade or status item
// depends on lob_pkg
`timescale 1ns / 1ps

interface lob_result_if;
  import lob_pkg::*;

  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [WORD_W-1:0] buyer_id;
  logic [WORD_W-1:0] seller_id;
  logic [WORD_W-1:0] trade_price;
  logic [WORD_W-1:0] trade_quantity;
  logic              last;

  modport source (output valid, kind, buyer_id, seller_id, trade_price, trade_quantity, last,
                  input ready);
  modport sink   (input valid, kind, buyer_id, seller_id, trade_price, trade_quantity, last,
                  output ready);
endinterface

FILE: rtl/lob_mem.sv
// book entry memory, one write port and one registered read port
// depends on lob_pkg
`timescale 1ns / 1ps

module lob_mem #(
  parameter int ADDR_W = 6
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  lob_pkg::entry_t       wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output lob_pkg::entry_t       rd_data
);
  import lob_pkg::*;

  entry_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

FILE: rtl/limit_order_book_matcher.sv
// limit order book matcher: price-time priority matching on a packed book
// depends on lob_pkg, lob_order_if, lob_result_if, lob_mem, assert_macros.svh
`timescale 1ns / 1ps
//
// usage:
//   orders  : valid/ready sink, one limit order item (id, side, price, quantity)
//   results : valid/ready source, zero or more trade items then one status item
//             with last set (rested, fully filled or rejected)
// both sides of the book live in one memory, packed from slot 0 in arrival order.
// an order is taken only when the matcher is idle; it then scans the opposite
// side, one memory read a cycle, to find the best price (oldest on ties).
// each fill scans the opposite side and then trades; a filled resting order
// leaving from the middle has each entry above it read and written one slot down.
// an order that does not cross ends with a status item after the scan; one
// with an empty opposite side reads nothing; a zero quantity skips the scan.
// the scan through the memory's single read port sets the rate.
// reset empties both sides at once through their fill counts; stored entries
// are not cleared.
// the result register holds an item while results.ready is low and the
// matcher waits with it; nothing is dropped.
//

`include "assert_macros.svh"

module limit_order_book_matcher #(
  parameter int BOOK_DEPTH = lob_pkg::LOB_BOOK_DEPTH
) (
  input logic         clk,
  input logic         rst,
  lob_order_if.sink   orders,
  lob_result_if.source results
);
  import lob_pkg::*;

  localparam int IDX_W  = $clog2(BOOK_DEPTH);
  localparam int CNT_W  = $clog2(BOOK_DEPTH + 1);
  localparam int ADDR_W = IDX_W + 1;

  state_t state, state_next;

  logic [WORD_W-1:0] cur_id, cur_limit, remain;
  logic              cur_sell;
  logic [CNT_W-1:0]  bid_cnt, ask_cnt;
  logic [IDX_W-1:0]  scan_idx, rd_idx, best_slot, sh_idx;
  logic              dv, have_best;
  entry_t            best;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_data, rd_data;

  logic [CNT_W-1:0]  opp_cnt, own_cnt;
  logic              opp_bit, own_bit;
  logic              out_free, out_load;
  logic [WORD_W-1:0] fill, ra_left, remain_left;
  logic              crosses, better, scan_last, slot_last, sh_done, own_full;

  lob_mem #(.ADDR_W(ADDR_W)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign opp_bit     = ~cur_sell;
  assign own_bit     = cur_sell;
  assign opp_cnt     = cur_sell ? bid_cnt : ask_cnt;
  assign own_cnt     = cur_sell ? ask_cnt : bid_cnt;
  assign own_full    = (own_cnt == CNT_W'(BOOK_DEPTH));
  assign out_free    = !results.valid || results.ready;
  assign fill        = (remain < best.amount) ? remain : best.amount;
  assign ra_left     = best.amount - fill;
  assign remain_left = remain - fill;
  assign crosses     = cur_sell ? (cur_limit <= best.price) : (cur_limit >= best.price);
  // bids: highest price wins, asks: lowest; strict so the older entry keeps ties
  assign better      = !have_best ||
                       (cur_sell ? (rd_data.price > best.price) : (rd_data.price < best.price));
  assign scan_last   = (CNT_W'(scan_idx) + CNT_W'(1) == opp_cnt);
  assign slot_last   = (CNT_W'(best_slot) + CNT_W'(1) == opp_cnt);
  assign sh_done     = (CNT_W'(sh_idx) + CNT_W'(2) == opp_cnt);

  assign orders.ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (orders.valid) begin
          state_next = (orders.quantity == '0) ? ST_STATUS : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (opp_cnt == '0) begin
          state_next = ST_STATUS;
        end else if (scan_last) begin
          state_next = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: state_next = ST_DECIDE;
      ST_DECIDE:    state_next = crosses ? ST_TRADE : ST_STATUS;
      ST_TRADE: begin
        if (out_free) begin
          if (ra_left != '0) begin
            state_next = ST_STATUS;
          end else if (slot_last) begin
            state_next = (remain_left != '0) ? ST_SCAN : ST_STATUS;
          end else begin
            state_next = ST_SHIFT_RD;
          end
        end
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (sh_done) begin
          state_next = (remain != '0) ? ST_SCAN : ST_STATUS;
        end else begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory and result register control
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = rd_data;
    out_load = 1'b0;
    case (state)
      ST_SCAN: begin
        rd_en   = (opp_cnt != '0);
        rd_addr = {opp_bit, scan_idx};
      end
      ST_TRADE: begin
        out_load = out_free;
        // partial fill of the resting order: write back its new amount
        wr_en    = out_free && (ra_left != '0);
        wr_addr  = {opp_bit, best_slot};
        wr_data  = '{price: best.price, amount: ra_left, id: best.id};
      end
      ST_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = {opp_bit, IDX_W'(sh_idx + IDX_W'(1))};
      end
      ST_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = {opp_bit, sh_idx};
        wr_data = rd_data;
      end
      ST_STATUS: begin
        out_load = out_free;
        wr_en    = out_free && (remain != '0) && !own_full;
        wr_addr  = {own_bit, IDX_W'(own_cnt)};
        wr_data  = '{price: cur_limit, amount: remain, id: cur_id};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      bid_cnt       <= '0;
      ask_cnt       <= '0;
      dv            <= 1'b0;
      have_best     <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= (state == ST_SCAN) && (opp_cnt != '0);

      if (out_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end

      if (state_next == ST_SCAN && state != ST_SCAN) begin
        have_best <= 1'b0;
      end else if (dv && better) begin
        have_best <= 1'b1;
      end

      // a filled resting order leaves its side
      if ((state == ST_TRADE && out_free && ra_left == '0 && slot_last) ||
          (state == ST_SHIFT_WR && sh_done)) begin
        if (cur_sell) begin
          bid_cnt <= bid_cnt - CNT_W'(1);
        end else begin
          ask_cnt <= ask_cnt - CNT_W'(1);
        end
      end
      if (state == ST_STATUS && wr_en) begin
        if (cur_sell) begin
          ask_cnt <= ask_cnt + CNT_W'(1);
        end else begin
          bid_cnt <= bid_cnt + CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && orders.valid) begin
      cur_id    <= orders.order_id;
      cur_sell  <= orders.side;
      cur_limit <= orders.limit_price;
      remain    <= orders.quantity;
    end else if (state == ST_TRADE && out_free) begin
      remain <= remain_left;
    end

    if (state_next == ST_SCAN && state != ST_SCAN) begin
      scan_idx <= '0;
    end else if (state == ST_SCAN && !scan_last) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    rd_idx <= scan_idx;

    if (dv && better) begin
      best      <= rd_data;
      best_slot <= rd_idx;
    end

    if (state == ST_TRADE) begin
      sh_idx <= best_slot;
    end else if (state == ST_SHIFT_WR) begin
      sh_idx <= sh_idx + IDX_W'(1);
    end

    if (out_load) begin
      if (state == ST_TRADE) begin
        results.kind           <= KIND_TRADE;
        results.buyer_id       <= cur_sell ? best.id : cur_id;
        results.seller_id      <= cur_sell ? cur_id : best.id;
        results.trade_price    <= best.price;
        results.trade_quantity <= fill;
        results.last           <= 1'b0;
      end else begin
        if (remain == '0) begin
          results.kind <= KIND_FILLED;
        end else if (own_full) begin
          results.kind <= KIND_REJECTED;
        end else begin
          results.kind <= KIND_RESTED;
        end
        results.buyer_id       <= cur_id;
        results.seller_id      <= cur_id;
        results.trade_price    <= '0;
        results.trade_quantity <= remain;
        results.last           <= 1'b1;
      end
    end
  end

  `LOB_ASSERT(a_cnt_range,
    (bid_cnt <= CNT_W'(BOOK_DEPTH)) && (ask_cnt <= CNT_W'(BOOK_DEPTH)),
    "book fill count beyond depth")
  `LOB_ASSERT(a_no_write_idle, !(state == ST_IDLE && wr_en),
    "memory written while idle")
  `LOB_ASSERT_NEXT(a_accept_busy, orders.valid && orders.ready, state != ST_IDLE,
    "accepted item did not start work")
  `LOB_ASSERT_NEXT(a_status_done, state == ST_STATUS && out_free,
    results.valid && results.last, "status item not presented")
endmodule
